FILE: rtl/double_ended_queue_unit_macros.svh
// Assertion macros for the double-ended queue unit.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define DEQ_ASSERT_NOW(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("double_ended_queue_unit: invariant violated");

// Check a consequence in the cycle after its trigger.
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("double_ended_queue_unit: sequence violated");

`endif

FILE: rtl/deq_pkg.sv
// Shared types and codes for the double-ended queue unit.
package deq_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int VALUE_W   = 32;
    localparam int REQ_W     = 3;
    localparam int COUNT_W   = 11;
    localparam int STATUS_W  = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH_LEFT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_RIGHT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_LEFT   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_RIGHT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ       = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic signed [VALUE_W-1:0] push_value;
    } req_beat_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] left_value;
        logic                      left_valid;
        logic signed [VALUE_W-1:0] right_value;
        logic                      right_valid;
        logic [COUNT_W-1:0]        entry_count;
        logic [STATUS_W-1:0]       status;
    } rsp_beat_t;

endpackage

FILE: rtl/deq_ram.sv
// Slot memory of the queue: one write port, one registered read port.
module deq_ram #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF,
    parameter int WIDTH = deq_pkg::VALUE_W
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/double_ended_queue_unit.sv
// Double-ended queue unit: ring buffer control, end-value cache and result register.
//
// Request channel req_valid/req_ready/req carries a request type (push left,
// push right, pop left, pop right, read) and a push value. Each request gives
// exactly one result beat on rsp_valid/rsp_ready/rsp: values at both ends with
// valid flags, the entry count and a status (ok, pop on empty, push on full).
// A request is taken in ST_IDLE, and in ST_DONE its result is loaded into the
// output register once that register is free; then the unit returns to ST_IDLE.
// The registered read port of the slot memory supplies the new end value after
// a pop, so a pop's result is formed in ST_DONE from the slot read at acceptance.
// One request is in progress at a time; the next is accepted while the result
// of the previous one still waits in the output register.
// If the receiver stalls, the finished result of the following request is held
// inside until the output register frees, and no further request is accepted.
// Reset empties the queue (both indices and the count go to zero); slot memory
// contents are not cleared and need no clearing pass.
`include "double_ended_queue_unit_macros.svh"

module double_ended_queue_unit #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  deq_pkg::req_beat_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output deq_pkg::rsp_beat_t rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    typedef enum logic {ST_IDLE, ST_DONE} state_t;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_LAST) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_LAST : i - 1'b1;
    endfunction

    state_t                          state_reg, state_next;
    logic [IDX_W-1:0]                left_idx_reg, left_idx_next;
    logic [IDX_W-1:0]                right_idx_reg, right_idx_next;
    logic [CNT_W-1:0]                occ_reg, occ_next;
    logic [deq_pkg::REQ_W-1:0]       op_reg, op_next;
    logic [deq_pkg::VALUE_W-1:0]     val_reg, val_next;
    logic [deq_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [deq_pkg::VALUE_W-1:0]     left_val_reg, left_val_next;
    logic [deq_pkg::VALUE_W-1:0]     right_val_reg, right_val_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    deq_pkg::rsp_beat_t              rsp_reg, rsp_next;

    logic                            req_fire;
    logic                            full, empty;
    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    logic [IDX_W-1:0]                rd_addr;
    logic [deq_pkg::VALUE_W-1:0]     rd_data;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign full      = (occ_reg == CNT_FULL);
    assign empty     = (occ_reg == '0);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    deq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (deq_pkg::VALUE_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.push_value),
        .rd_en   (req_fire),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        left_idx_next  = left_idx_reg;
        right_idx_next = right_idx_reg;
        occ_next       = occ_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        status_next    = status_reg;
        left_val_next  = left_val_reg;
        right_val_next = right_val_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        wr_en          = 1'b0;
        wr_addr        = right_idx_reg;
        rd_addr        = wrap_inc(left_idx_reg);

        case (req.req_type)
            deq_pkg::REQ_PUSH_LEFT:  wr_addr = wrap_dec(left_idx_reg);
            deq_pkg::REQ_POP_RIGHT:  rd_addr = wrap_dec(wrap_dec(right_idx_reg));
            default:                 wr_addr = right_idx_reg;
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    op_next     = req.req_type;
                    val_next    = req.push_value;
                    status_next = deq_pkg::STATUS_OK;
                    state_next  = ST_DONE;
                    case (req.req_type)
                        deq_pkg::REQ_PUSH_LEFT:
                        begin
                            if (full)
                            begin
                                status_next = deq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                left_idx_next = wrap_dec(left_idx_reg);
                                occ_next      = occ_reg + 1'b1;
                            end
                        end
                        deq_pkg::REQ_PUSH_RIGHT:
                        begin
                            if (full)
                            begin
                                status_next = deq_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                right_idx_next = wrap_inc(right_idx_reg);
                                occ_next       = occ_reg + 1'b1;
                            end
                        end
                        deq_pkg::REQ_POP_LEFT:
                        begin
                            if (empty)
                            begin
                                status_next = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                left_idx_next = wrap_inc(left_idx_reg);
                                occ_next      = occ_reg - 1'b1;
                            end
                        end
                        deq_pkg::REQ_POP_RIGHT:
                        begin
                            if (empty)
                            begin
                                status_next = deq_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                right_idx_next = wrap_dec(right_idx_reg);
                                occ_next       = occ_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = deq_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    if (status_reg == deq_pkg::STATUS_OK)
                    begin
                        case (op_reg)
                            deq_pkg::REQ_PUSH_LEFT:
                            begin
                                left_val_next = val_reg;
                                if (occ_reg == CNT_W'(1))
                                begin
                                    right_val_next = val_reg;
                                end
                            end
                            deq_pkg::REQ_PUSH_RIGHT:
                            begin
                                right_val_next = val_reg;
                                if (occ_reg == CNT_W'(1))
                                begin
                                    left_val_next = val_reg;
                                end
                            end
                            deq_pkg::REQ_POP_LEFT:
                            begin
                                left_val_next = (occ_reg == CNT_W'(1)) ? right_val_reg : rd_data;
                            end
                            deq_pkg::REQ_POP_RIGHT:
                            begin
                                right_val_next = (occ_reg == CNT_W'(1)) ? left_val_reg : rd_data;
                            end
                            default:
                            begin
                                left_val_next = left_val_reg;
                            end
                        endcase
                    end
                    rsp_next.left_valid  = !empty;
                    rsp_next.right_valid = !empty;
                    rsp_next.left_value  = empty ? '0 : left_val_next;
                    rsp_next.right_value = empty ? '0 : right_val_next;
                    rsp_next.entry_count = deq_pkg::COUNT_W'(occ_reg);
                    rsp_next.status      = status_reg;
                    rsp_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_idx_reg  <= '0;
            right_idx_reg <= '0;
            occ_reg       <= '0;
            op_reg        <= deq_pkg::REQ_READ;
            val_reg       <= '0;
            status_reg    <= deq_pkg::STATUS_OK;
            left_val_reg  <= '0;
            right_val_reg <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            left_idx_reg  <= left_idx_next;
            right_idx_reg <= right_idx_next;
            occ_reg       <= occ_next;
            op_reg        <= op_next;
            val_reg       <= val_next;
            status_reg    <= status_next;
            left_val_reg  <= left_val_next;
            right_val_reg <= right_val_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    `DEQ_ASSERT_NOW(a_occ_bound, clk, rst_n, occ_reg <= CNT_FULL)
    `DEQ_ASSERT_NOW(a_ring_ends, clk, rst_n, !(empty || full) || (left_idx_reg == right_idx_reg))
    `DEQ_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_fire, !req_ready)

endmodule

FILE: test/tb_top.sv
// Testbench for double_ended_queue_unit: mirrored deque model, random traffic and stalls.
`timescale 1ns / 100ps

module tb_top;

    localparam int QUEUE_DEPTH = deq_pkg::DEPTH_DEF;
    localparam logic [deq_pkg::REQ_W-1:0] REQ_SPARE_LO  = 3'd5;
    localparam logic [deq_pkg::REQ_W-1:0] REQ_SPARE_MID = 3'd6;
    localparam logic [deq_pkg::REQ_W-1:0] REQ_SPARE_HI  = 3'd7;
    localparam int RANDOM_ITEMS = 480;
    localparam int HOLD_START = 300;
    localparam int HOLD_CYCLES = 400;

    class deque_scoreboard;
        logic signed [deq_pkg::VALUE_W-1:0] slots [QUEUE_DEPTH];
        int unsigned left_slot;
        int unsigned right_slot;
        int unsigned occupancy;
        deq_pkg::rsp_beat_t expected_views[$];
        int mismatches;
        int beats_seen;

        function new();
            left_slot = 0;
            right_slot = 0;
            occupancy = 0;
            mismatches = 0;
            beats_seen = 0;
        endfunction

        function int unsigned step_back(int unsigned i);
            return (i == 0) ? QUEUE_DEPTH - 1 : i - 1;
        endfunction

        function int unsigned step_fwd(int unsigned i);
            return (i + 1 >= QUEUE_DEPTH) ? 0 : i + 1;
        endfunction

        function void apply_request(deq_pkg::req_beat_t r);
            deq_pkg::rsp_beat_t view;
            logic [deq_pkg::STATUS_W-1:0] code;
            logic is_full;
            logic is_empty;
            code = deq_pkg::STATUS_OK;
            is_full = (occupancy >= QUEUE_DEPTH);
            is_empty = (occupancy == 0);
            case (r.req_type)
                deq_pkg::REQ_PUSH_LEFT:
                    if (is_full) code = deq_pkg::STATUS_FULL;
                    else
                    begin
                        left_slot = step_back(left_slot);
                        slots[left_slot] = r.push_value;
                        occupancy++;
                    end
                deq_pkg::REQ_PUSH_RIGHT:
                    if (is_full) code = deq_pkg::STATUS_FULL;
                    else
                    begin
                        slots[right_slot] = r.push_value;
                        right_slot = step_fwd(right_slot);
                        occupancy++;
                    end
                deq_pkg::REQ_POP_LEFT:
                    if (is_empty) code = deq_pkg::STATUS_EMPTY;
                    else
                    begin
                        left_slot = step_fwd(left_slot);
                        occupancy--;
                    end
                deq_pkg::REQ_POP_RIGHT:
                    if (is_empty) code = deq_pkg::STATUS_EMPTY;
                    else
                    begin
                        right_slot = step_back(right_slot);
                        occupancy--;
                    end
                default: ;
            endcase
            view = '0;
            if (occupancy != 0)
            begin
                view.left_value = slots[left_slot];
                view.left_valid = 1'b1;
                view.right_value = slots[step_back(right_slot)];
                view.right_valid = 1'b1;
            end
            view.entry_count = occupancy[deq_pkg::COUNT_W-1:0];
            view.status = code;
            expected_views.push_back(view);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            mismatches++;
            $display("mismatch at beat %0d on %s: got %h, expected %h",
                     beats_seen, what, got, want);
        endtask

        task check_view(deq_pkg::rsp_beat_t got);
            deq_pkg::rsp_beat_t want;
            beats_seen++;
            if (expected_views.size() == 0)
            begin
                report_mismatch("unexpected beat", '0, '0);
                return;
            end
            want = expected_views.pop_front();
            if (got.left_value !== want.left_value)
                report_mismatch("left_value", 64'(got.left_value), 64'(want.left_value));
            if (got.left_valid !== want.left_valid)
                report_mismatch("left_valid", 64'(got.left_valid), 64'(want.left_valid));
            if (got.right_value !== want.right_value)
                report_mismatch("right_value", 64'(got.right_value), 64'(want.right_value));
            if (got.right_valid !== want.right_valid)
                report_mismatch("right_valid", 64'(got.right_valid), 64'(want.right_valid));
            if (got.entry_count !== want.entry_count)
                report_mismatch("entry_count", 64'(got.entry_count), 64'(want.entry_count));
            if (got.status !== want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    deq_pkg::req_beat_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    deq_pkg::rsp_beat_t rsp;

    deque_scoreboard sb = new();
    int burst_left = 0;

    double_ended_queue_unit #(.DEPTH(QUEUE_DEPTH)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_view(rsp);
    end

    function automatic logic [deq_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input logic [deq_pkg::REQ_W-1:0] kind,
                                input logic [deq_pkg::VALUE_W-1:0] value);
        deq_pkg::req_beat_t r;
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 9) < 3) gap = 0;
            else if ($urandom_range(0, 9) == 0) gap = $urandom_range(10, 30);
            else gap = $urandom_range(1, 5);
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        r.req_type = kind;
        r.push_value = value;
        @(negedge clk);
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (!req_ready);
        sb.apply_request(r);
    endtask

    // receiver: ready pattern in spans, one long hold-off
    initial
    begin
        int cycle;
        int mode;
        int span;
        cycle = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            repeat (span)
            begin
                @(negedge clk);
                cycle++;
                if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES)
                    rsp_ready <= 1'b0;
                else
                    case (mode)
                        0: rsp_ready <= 1'b1;
                        1: rsp_ready <= 1'($urandom_range(0, 1));
                        2: rsp_ready <= ($urandom_range(0, 7) == 0);
                        default: rsp_ready <= cycle[1];
                    endcase
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        deq_pkg::req_beat_t directed [$];
        int pick;
        int wait_cycles;
        directed = '{
            '{deq_pkg::REQ_READ, 32'h0}, '{deq_pkg::REQ_POP_LEFT, 32'h1},
            '{deq_pkg::REQ_POP_RIGHT, 32'h2},
            '{deq_pkg::REQ_PUSH_LEFT, 32'h7fff_ffff}, '{deq_pkg::REQ_POP_LEFT, 32'h0},
            '{deq_pkg::REQ_PUSH_RIGHT, 32'h8000_0000}, '{deq_pkg::REQ_POP_RIGHT, 32'h0},
            '{deq_pkg::REQ_PUSH_RIGHT, 32'h8000_0000},
            '{deq_pkg::REQ_PUSH_LEFT, 32'h7fff_ffff},
            '{deq_pkg::REQ_PUSH_LEFT, 32'hffff_ffff}, '{deq_pkg::REQ_PUSH_RIGHT, 32'h0},
            '{REQ_SPARE_LO, 32'h1234_5678}, '{REQ_SPARE_MID, 32'ha5a5_a5a5},
            '{REQ_SPARE_HI, 32'h5a5a_5a5a}, '{deq_pkg::REQ_READ, 32'hffff_ffff},
            '{deq_pkg::REQ_POP_LEFT, 32'h0}, '{deq_pkg::REQ_POP_RIGHT, 32'h0},
            '{deq_pkg::REQ_POP_LEFT, 32'h0}, '{deq_pkg::REQ_POP_RIGHT, 32'h0},
            '{deq_pkg::REQ_POP_LEFT, 32'h0}
        };
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_request(directed[i].req_type, directed[i].push_value);

        repeat (RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25) send_request(deq_pkg::REQ_PUSH_LEFT, pick_value());
            else if (pick < 50) send_request(deq_pkg::REQ_PUSH_RIGHT, pick_value());
            else if (pick < 72) send_request(deq_pkg::REQ_POP_LEFT, pick_value());
            else if (pick < 94) send_request(deq_pkg::REQ_POP_RIGHT, pick_value());
            else if (pick < 97) send_request(deq_pkg::REQ_READ, pick_value());
            else send_request(deq_pkg::REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)),
                              pick_value());
        end

        // drain to empty, then pop against an empty queue
        while (sb.occupancy > 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10) send_request(deq_pkg::REQ_PUSH_LEFT, pick_value());
            else if (pick < 15) send_request(deq_pkg::REQ_READ, pick_value());
            else if (pick < 57) send_request(deq_pkg::REQ_POP_LEFT, pick_value());
            else send_request(deq_pkg::REQ_POP_RIGHT, pick_value());
        end
        send_request(deq_pkg::REQ_POP_LEFT, pick_value());
        send_request(deq_pkg::REQ_POP_RIGHT, pick_value());

        @(negedge clk);
        req_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.expected_views.size() > 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_views.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
